/* src/crc8cfr_pkg.sv */
// shared types, constants and functions of the crc-8 command frame receiver
`default_nettype none
package crc8cfr_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 8;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COMMAND  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_PAYLOAD0 = POS_W'(2);
    localparam logic [POS_W-1:0] CRC_LAST_POS = POS_W'(5);
    localparam logic [POS_W-1:0] POS_CRC      = POS_W'(6);
    localparam logic [POS_W-1:0] POS_TAIL     = POS_W'(FRAME_BYTES - 1);

    // crc and command codes
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  REBOOT_CODE = 8'hFF;
    localparam logic [31:0] SIGN_MASK   = 32'h8000_0000;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_CMD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOWER   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_UPPER   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT = 3'd5;

    // configuration register file contents
    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  trailer_byte;
        logic [7:0]  set_target_code;
        logic [31:0] lower_limit;
        logic [31:0] upper_limit;
        logic [31:0] default_target;
    } t_cfg;

    // closed frame handed from the byte assembler to the decision stage
    typedef struct packed {
        logic        frame_ok;
        logic        crc_ok;
        logic [7:0]  command;
        logic [31:0] payload;
        logic        converter_on;
    } t_frame_ev;

    // one result item
    typedef struct packed {
        logic        frame_ok;
        logic        crc_ok;
        logic        reboot_request;
        logic        target_updated;
        logic [31:0] bus_target;
        logic        load_reference;
    } t_result;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // unsigned key that sorts ieee single bits in sign-magnitude order
    function automatic logic [31:0] order_key(input logic [31:0] x);
        return x[31] ? ~x : (x | SIGN_MASK);
    endfunction

endpackage
`default_nettype wire

/* src/crc8cfr_regs.sv */
// configuration register file
`default_nettype none
module crc8cfr_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [crc8cfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]                        i_cfg_data,
    output logic                                    o_cfg_ready,
    output crc8cfr_pkg::t_cfg                       o_cfg
);
    import crc8cfr_pkg::*;

    t_cfg r_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_HEADER:  r_cfg.header_byte     <= i_cfg_data[7:0];
                CFG_TAIL:    r_cfg.trailer_byte    <= i_cfg_data[7:0];
                CFG_SET_CMD: r_cfg.set_target_code <= i_cfg_data[7:0];
                CFG_LOWER:   r_cfg.lower_limit     <= i_cfg_data;
                CFG_UPPER:   r_cfg.upper_limit     <= i_cfg_data;
                CFG_DEFAULT: r_cfg.default_target  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/crc8cfr_frame.sv */
// byte assembler: frame position, running crc, header check and closed-frame register
`default_nettype none
module crc8cfr_frame (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [7:0]              i_byte,
    input  wire logic                    i_converter_on,
    input  wire crc8cfr_pkg::t_cfg       i_cfg,
    input  wire logic                    i_ev_ready,
    output logic                         o_ready,
    output logic                         o_ev_valid,
    output crc8cfr_pkg::t_frame_ev       o_ev
);
    import crc8cfr_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic             r_hdr_ok, n_hdr_ok;
    logic [7:0]       r_cmd;
    logic [31:0]      r_payload;
    logic             r_ev_valid, n_ev_valid;
    t_frame_ev        r_ev;
    logic             accept;
    logic             last_byte;
    logic [1:0]       pay_idx;

    // the tail byte needs a free slot in the event register
    assign o_ready    = (r_pos != POS_TAIL) || !r_ev_valid || i_ev_ready;
    assign accept     = i_valid && o_ready;
    assign last_byte  = (r_pos == POS_TAIL);
    assign pay_idx    = 2'(r_pos - POS_PAYLOAD0);
    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    // position, crc and header tracking
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_hdr_ok = r_hdr_ok;
        if (accept) begin
            n_pos = last_byte ? POS_HEADER : r_pos + POS_W'(1);
            if (r_pos == POS_HEADER) begin
                n_hdr_ok = (i_byte == i_cfg.header_byte);
                n_crc    = 8'h00;
            end else if (r_pos <= CRC_LAST_POS) begin
                n_crc = crc8_byte(r_crc, i_byte);
            end else if (r_pos == POS_CRC) begin
                n_crc = r_crc ^ i_byte;
            end
        end
    end

    // event slot fills on the tail byte and drains when the next stage takes it
    always_comb begin
        n_ev_valid = r_ev_valid;
        if (i_ev_ready) begin
            n_ev_valid = 1'b0;
        end
        if (accept && last_byte) begin
            n_ev_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_HEADER;
            r_crc      <= 8'h00;
            r_hdr_ok   <= 1'b0;
            r_ev_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_hdr_ok   <= n_hdr_ok;
            r_ev_valid <= n_ev_valid;
        end
    end

    // command, payload and closed frame contents
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_pos == POS_COMMAND) begin
                r_cmd <= i_byte;
            end else if (r_pos > POS_COMMAND && r_pos <= CRC_LAST_POS) begin
                r_payload[8*pay_idx +: 8] <= i_byte;
            end
            if (last_byte) begin
                r_ev.frame_ok     <= r_hdr_ok && (i_byte == i_cfg.trailer_byte);
                r_ev.crc_ok       <= (r_crc == 8'h00);
                r_ev.command      <= r_cmd;
                r_ev.payload      <= r_payload;
                r_ev.converter_on <= i_converter_on;
            end
        end
    end

endmodule
`default_nettype wire

/* src/crc8cfr_decide.sv */
// command decision, stored target and result register
`default_nettype none
module crc8cfr_decide (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_ev_valid,
    input  wire crc8cfr_pkg::t_frame_ev  i_ev,
    input  wire crc8cfr_pkg::t_cfg       i_cfg,
    input  wire logic                    i_out_ready,
    output logic                         o_ev_ready,
    output logic                         o_out_valid,
    output crc8cfr_pkg::t_result         o_out
);
    import crc8cfr_pkg::*;

    logic [31:0] r_stored;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        take;
    logic        frame_valid;
    logic        reboot;
    logic        update;
    logic [31:0] cand;
    logic [31:0] cand_key;
    logic        in_range;

    assign o_ev_ready  = !r_out_valid || i_out_ready;
    assign take        = i_ev_valid && o_ev_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // classify the frame and pick the target
    always_comb begin
        frame_valid = i_ev.frame_ok && i_ev.crc_ok;
        reboot      = frame_valid && (i_ev.command == REBOOT_CODE);
        update      = frame_valid && !reboot && (i_ev.command == i_cfg.set_target_code);
        cand        = update ? i_ev.payload : r_stored;
        cand_key    = order_key(cand);
        in_range    = (cand_key > order_key(i_cfg.lower_limit)) &&
                      (cand_key < order_key(i_cfg.upper_limit));

        n_out.frame_ok       = i_ev.frame_ok;
        n_out.crc_ok         = i_ev.crc_ok;
        n_out.reboot_request = reboot;
        n_out.target_updated = update;
        n_out.bus_target     = reboot ? 32'h0 : (in_range ? cand : i_cfg.default_target);
        n_out.load_reference = !reboot && i_ev.converter_on;
    end

    // stored target and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored    <= 32'h0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ev_ready) begin
                r_out_valid <= i_ev_valid;
            end
            if (take && update) begin
                r_stored <= i_ev.payload;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* src/crc8_command_frame_receiver.sv */
// top level of the crc-8 command frame receiver
//
// Received bytes enter on s_axis, one byte per item with the converter-on flag
// in s_axis_tuser. Every eighth byte closes a frame (header, command, four
// little-endian payload bytes, crc-8 poly 0x07 over bytes 1..5, tail); there is
// no resynchronization. Each frame yields one result item on m_axis carrying
// the chosen bus voltage target in tdata and the status flags in tuser.
// Registers are written through the cfg channel, one write per cycle; the user
// must write them only while the block is idle, which the block does not check.
// Throughput: one byte per cycle while the tail byte is not held off. A closed
// frame passes the event register and then the result register, with the target
// compare between those two, before m_axis_tvalid rises.
// While a result waits on m_axis_tready the first seven bytes of the next frame
// are still taken; its tail byte is held off only while both the event register
// and the result register are full.
// Synchronous reset clears position, crc, registers, stored target and the
// event and output valids; a frame or result in flight at reset is dropped.
`default_nettype none
module crc8_command_frame_receiver (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                               s_axis_tuser,  // [0] converter_on
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [31:0]                             m_axis_tdata,  // [31:0] bus_target
    // [0] frame_ok, [1] crc_ok, [2] reboot_request, [3] target_updated,
    // [4] load_reference
    output logic [4:0]                              m_axis_tuser,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [crc8cfr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [31:0]                        i_cfg_data
);
    import crc8cfr_pkg::*;

    t_cfg      cfg;
    t_frame_ev ev;
    logic      ev_valid;
    logic      ev_ready;
    t_result   res;

    // register file
    crc8cfr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // byte assembler
    crc8cfr_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_byte         (s_axis_tdata),
        .i_converter_on (s_axis_tuser),
        .i_cfg          (cfg),
        .i_ev_ready     (ev_ready),
        .o_ready        (s_axis_tready),
        .o_ev_valid     (ev_valid),
        .o_ev           (ev)
    );

    // decision and result register
    crc8cfr_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (ev_valid),
        .i_ev        (ev),
        .i_cfg       (cfg),
        .i_out_ready (m_axis_tready),
        .o_ev_ready  (ev_ready),
        .o_out_valid (m_axis_tvalid),
        .o_out       (res)
    );

    // result packing
    assign m_axis_tdata = res.bus_target;
    assign m_axis_tuser = {res.load_reference, res.target_updated, res.reboot_request,
                           res.crc_ok, res.frame_ok};

endmodule
`default_nettype wire

/* src/crc8cfr_checker.sv */
// port-level assertions for the crc-8 command frame receiver and their binding
`default_nettype none
module crc8cfr_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [31:0]                        m_axis_tdata,
    input  wire logic [4:0]                         m_axis_tuser
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // reboot results carry no target, no load and no update
    a_reboot_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tdata == 32'h0 && !m_axis_tuser[4] && !m_axis_tuser[3])
        else $error("reboot result carries target data");

    // reboot or target update only on a frame with good framing and crc
    a_action_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2] || m_axis_tuser[3]) |->
            m_axis_tuser[0] && m_axis_tuser[1])
        else $error("action taken on an invalid frame");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind crc8_command_frame_receiver crc8cfr_checker u_checker (.*);
`default_nettype wire

/* tb/crc8_command_frame_receiver_tb.sv */
// testbench for the crc-8 command frame receiver: scoreboard, byte stream drivers and checks
`timescale 1ns / 100ps

import crc8cfr_pkg::*;

// tracks the frame decoder and holds the frame results still to come
class crc8_frame_scoreboard;
    t_cfg        regs;
    bit [2:0]    byte_pos;
    bit [7:0]    crc_acc;
    bit          hdr_hit;
    bit [7:0]    cmd;
    bit [31:0]   payload;
    bit [31:0]   held_target;
    t_result     frame_results_due[$];
    int          errors;

    function new();
        regs        = '0;
        byte_pos    = POS_HEADER;
        crc_acc     = '0;
        hdr_hit     = 1'b0;
        cmd         = '0;
        payload     = '0;
        held_target = '0;
        errors      = 0;
    endfunction

    // crc-8, poly 0x07, one byte shifted in msb first
    function bit [7:0] crc_step(bit [7:0] acc, bit [7:0] b);
        bit [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // a strictly below b when both are read as sign-magnitude numbers
    function bit sm_below(bit [31:0] a, bit [31:0] b);
        if (a[31] != b[31]) begin
            return a[31];
        end
        return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
    endfunction

    // register write accepted by the block
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        case (idx)
            CFG_HEADER:  regs.header_byte     = val[7:0];
            CFG_TAIL:    regs.trailer_byte    = val[7:0];
            CFG_SET_CMD: regs.set_target_code = val[7:0];
            CFG_LOWER:   regs.lower_limit     = val;
            CFG_UPPER:   regs.upper_limit     = val;
            CFG_DEFAULT: regs.default_target  = val;
            default: ;
        endcase
    endfunction

    // byte accepted on the input stream; a closing byte queues one frame result
    function void note_byte(bit [7:0] b, bit on);
        t_result r;
        bit      good;
        case (byte_pos)
            POS_HEADER: begin
                hdr_hit = (b == regs.header_byte);
                crc_acc = '0;
            end
            POS_COMMAND: begin
                crc_acc = crc_step(crc_acc, b);
                cmd     = b;
            end
            POS_CRC:  crc_acc = crc_acc ^ b;
            POS_TAIL: ;
            default: begin
                crc_acc = crc_step(crc_acc, b);
                payload[8*(byte_pos - POS_PAYLOAD0) +: 8] = b;
            end
        endcase
        if (byte_pos != POS_TAIL) begin
            byte_pos++;
            return;
        end
        byte_pos = POS_HEADER;

        r          = '0;
        r.frame_ok = hdr_hit && (b == regs.trailer_byte);
        r.crc_ok   = (crc_acc == 8'h00);
        good       = r.frame_ok && r.crc_ok;
        if (good && cmd == REBOOT_CODE) begin
            r.reboot_request = 1'b1;
        end else begin
            if (good && cmd == regs.set_target_code) begin
                held_target      = payload;
                r.target_updated = 1'b1;
            end
            if (sm_below(regs.lower_limit, held_target) &&
                sm_below(held_target, regs.upper_limit)) begin
                r.bus_target = held_target;
            end else begin
                r.bus_target = regs.default_target;
            end
            r.load_reference = on;
        end
        frame_results_due.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            errors++;
        end
    endfunction

    // result item accepted on the output stream
    function void check_result(logic [31:0] tdata, logic [4:0] tuser);
        t_result e;
        if (frame_results_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                     $time, tdata, tuser);
            errors++;
            return;
        end
        e = frame_results_due.pop_front();
        compare("frame_ok", e.frame_ok, tuser[0]);
        compare("crc_ok", e.crc_ok, tuser[1]);
        compare("reboot_request", e.reboot_request, tuser[2]);
        compare("target_updated", e.target_updated, tuser[3]);
        compare("load_reference", e.load_reference, tuser[4]);
        compare("bus_target", e.bus_target, tdata);
    endfunction
endclass

module crc8_command_frame_receiver_tb;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic [4:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [31:0]           i_cfg_data = '0;

    crc8_frame_scoreboard sb = new();

    int src_idle = 33;
    int snk_idle = 50;
    int stall_left = 0;

    crc8_command_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("crc8_command_frame_receiver test failed");
        $finish;
    end

    // result side: check accepted items, random back-pressure with rare long stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (snk_idle != 0 && $urandom_range(199) == 0) begin
            stall_left    <= $urandom_range(40, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // one byte on the input stream, with random idle cycles ahead of it
    task automatic send_byte(input bit [7:0] b, input bit on);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= b;
        s_axis_tuser  <= on;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, on);
    endtask

    // whole frame; crc_flip corrupts the crc byte, on goes with the tail byte
    task automatic send_frame(input bit [7:0] hdr, input bit [7:0] cmd,
                              input bit [31:0] payload, input bit [7:0] crc_flip,
                              input bit [7:0] tail, input bit on);
        bit [7:0] bytes [8];
        bit [7:0] crc;
        bytes[0] = hdr;
        bytes[1] = cmd;
        for (int i = 0; i < 4; i++) begin
            bytes[2+i] = payload[8*i +: 8];
        end
        crc = '0;
        for (int i = 1; i < 6; i++) begin
            crc = sb.crc_step(crc, bytes[i]);
        end
        bytes[6] = crc ^ crc_flip;
        bytes[7] = tail;
        for (int i = 0; i < 8; i++) begin
            send_byte(bytes[i], (i == 7) ? on : 1'($urandom_range(1)));
        end
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(a, d);
    endtask

    task automatic program_regs(input t_cfg c);
        cfg_write(CFG_HEADER, {24'd0, c.header_byte});
        cfg_write(CFG_TAIL, {24'd0, c.trailer_byte});
        cfg_write(CFG_SET_CMD, {24'd0, c.set_target_code});
        cfg_write(CFG_LOWER, c.lower_limit);
        cfg_write(CFG_UPPER, c.upper_limit);
        cfg_write(CFG_DEFAULT, c.default_target);
        i_cfg_valid <= 1'b0;
    endtask

    // hold the input until every frame result is out, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.frame_results_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, some broken ones and stray bytes
    task automatic random_frame();
        int       kind;
        int       r;
        bit [7:0] cmd;
        bit [31:0] pl;
        bit [7:0] hdr;
        bit [7:0] tail;
        bit [7:0] flip;
        // realign after stray bytes
        while (sb.byte_pos != POS_HEADER) begin
            send_byte(8'($urandom), 1'($urandom_range(1)));
        end
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(7, 1)) send_byte(8'($urandom), 1'($urandom_range(1)));
            return;
        end
        if (kind < 10) begin
            repeat (8) send_byte(8'($urandom), 1'($urandom_range(1)));
            return;
        end
        r = $urandom_range(99);
        if (r < 40) begin
            cmd = sb.regs.set_target_code;
        end else if (r < 52) begin
            cmd = REBOOT_CODE;
        end else begin
            cmd = 8'($urandom);
        end
        if ($urandom_range(99) < 35) begin
            case ($urandom_range(12))
                0:  pl = 32'h0000_0000;
                1:  pl = 32'h8000_0000;
                2:  pl = 32'h7F80_0000;
                3:  pl = 32'hFF80_0000;
                4:  pl = 32'h7FC0_0000;
                5:  pl = 32'hFFFF_FFFF;
                6:  pl = 32'h7FFF_FFFF;
                7:  pl = sb.regs.lower_limit;
                8:  pl = sb.regs.upper_limit;
                9:  pl = sb.regs.lower_limit + 1;
                10: pl = sb.regs.lower_limit - 1;
                11: pl = sb.regs.upper_limit + 1;
                default: pl = sb.regs.upper_limit - 1;
            endcase
        end else begin
            pl = $urandom;
        end
        hdr  = sb.regs.header_byte;
        tail = sb.regs.trailer_byte;
        flip = 8'h00;
        if (kind >= 80 && kind < 87) begin
            hdr = hdr ^ 8'($urandom_range(255, 1));
        end else if (kind >= 87 && kind < 93) begin
            tail = tail ^ 8'($urandom_range(255, 1));
        end else if (kind >= 93) begin
            flip = 8'($urandom_range(255, 1));
        end
        send_frame(hdr, cmd, pl, flip, tail, 1'($urandom_range(1)));
    endtask

    // main sequence
    initial begin
        t_cfg c;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: set-target code 0 updates, empty range picks default
        send_frame(8'h00, 8'h00, 32'h3F80_0000, 8'h00, 8'h00, 1'b1);
        settle();

        c = '{header_byte: 8'hA5, trailer_byte: 8'h5A, set_target_code: 8'h3C,
              lower_limit: 32'hC2C8_0000, upper_limit: 32'h42C8_0000,
              default_target: 32'h4240_0000};
        program_regs(c);
        // in-range set-target, converter off
        send_frame(8'hA5, 8'h3C, 32'h4140_0000, 8'h00, 8'h5A, 1'b0);
        // reboot leaves the target alone
        send_frame(8'hA5, REBOOT_CODE, 32'h4300_0000, 8'h00, 8'h5A, 1'b1);
        // crc error on a set-target frame
        send_frame(8'hA5, 8'h3C, 32'h4100_0000, 8'h01, 8'h5A, 1'b1);
        // header and tail both wrong, valid crc
        send_frame(8'h5A, 8'h3C, 32'h4100_0000, 8'h00, 8'hA5, 1'b1);

        for (int p = 0; p < 6; p++) begin
            settle();
            if (p < 2) begin
                src_idle = 33;
                snk_idle = 50;
            end else if (p < 4) begin
                src_idle = 50;
                snk_idle = 33;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            case (p)
                // all-ones extremes: set-target code collides with reboot
                0: c = '{8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
                // zero extremes: nothing lies strictly between -0 and +0
                1: c = '{8'h00, 8'h00, 8'h00, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000};
                default: begin
                    c.header_byte     = 8'($urandom);
                    c.trailer_byte    = 8'($urandom);
                    c.set_target_code = 8'($urandom);
                    c.lower_limit     = {1'b1, 31'($urandom)};
                    c.upper_limit     = {2'b01, 30'($urandom)};
                    c.default_target  = $urandom;
                end
            endcase
            program_regs(c);
            repeat (36) random_frame();
            while (sb.byte_pos != POS_HEADER) begin
                send_byte(8'($urandom), 1'($urandom_range(1)));
            end
        end

        settle();
        if (sb.errors == 0 && sb.frame_results_due.size() == 0) begin
            $display("crc8_command_frame_receiver test passed");
        end else begin
            $display("crc8_command_frame_receiver test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/crc8cfr_pkg.sv
src/crc8cfr_regs.sv
src/crc8cfr_frame.sv
src/crc8cfr_decide.sv
src/crc8_command_frame_receiver.sv
src/crc8cfr_checker.sv
tb/crc8_command_frame_receiver_tb.sv
